/* hw/rtl/lmfs_pkg.sv */
// Shared types, field widths and defaults for the LED matrix frame scanner.
`default_nettype none

package lmfs_pkg;

  localparam int unsigned PANEL_WIDTH_DEF = 64;
  localparam int unsigned HALF_ROWS_DEF   = 16;

  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned RGB_W      = 3;
  localparam int unsigned ROW_ADDR_W = 4;
  localparam int unsigned COL_IDX_W  = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SET  = 2'd0,
    OP_CLR  = 2'd1,
    OP_SCAN = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX_WR,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic pix_accept;
    logic pix_wr;
    logic scan_issue;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic col_last;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/lmfs_if.sv */
// Valid/ready channel interfaces for pixel/scan items and column results.
`default_nettype none

interface lmfs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [lmfs_pkg::OPCODE_W-1:0] opcode;
  logic signed [lmfs_pkg::COORD_W-1:0]  pixel_row;
  logic signed [lmfs_pkg::COORD_W-1:0]  pixel_col;
  logic        [lmfs_pkg::RGB_W-1:0]    color;

  modport source (output valid, opcode, pixel_row, pixel_col, color, input ready);
  modport sink   (input valid, opcode, pixel_row, pixel_col, color, output ready);
endinterface

interface lmfs_out_if;
  logic                              valid;
  logic                              ready;
  logic [lmfs_pkg::RGB_W-1:0]        upper_rgb;
  logic [lmfs_pkg::RGB_W-1:0]        lower_rgb;
  logic [lmfs_pkg::ROW_ADDR_W-1:0]   row_address;
  logic [lmfs_pkg::COL_IDX_W-1:0]    column_index;
  logic                              last_column;

  modport source (output valid, upper_rgb, lower_rgb, row_address, column_index,
                  last_column, input ready);
  modport sink   (input valid, upper_rgb, lower_rgb, row_address, column_index,
                  last_column, output ready);
endinterface

`default_nettype wire

/* hw/rtl/led_matrix_frame_scan.sv */
// Top level of the split-scan LED matrix frame store and row scanner.
//
//   channel  dir  handshake          payload
//   in_i     in   valid / ready      opcode, pixel_row, pixel_col, color
//   out_o    out  valid / ready      upper_rgb, lower_rgb, row_address,
//                                    column_index, last_column
//
// After reset a clearing pass writes zero to all HALF_ROWS * 2**clog2(PANEL_WIDTH)
// memory entries (1024 at defaults), one a cycle; in_i.ready is low meanwhile.
// Set and clear pixel items read, then write, the frame memory. A scan item issues
// PANEL_WIDTH column reads on the scan read port, one a cycle while out_o does not
// stall. A stall on out_o holds the two-stage read/output pipeline and the column
// reads wait; the next item is taken while the last columns drain.
`default_nettype none

module led_matrix_frame_scan #(
  parameter int unsigned PANEL_WIDTH = lmfs_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned HALF_ROWS   = lmfs_pkg::HALF_ROWS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lmfs_in_if.sink     in_i,
  lmfs_out_if.source  out_o
);

  lmfs_pkg::cmd_t   cmd;
  lmfs_pkg::sts_t   sts;
  lmfs_pkg::state_e state;

  lmfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  lmfs_dp #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .HALF_ROWS   (HALF_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_opcode_i        (in_i.opcode),
    .in_pixel_row_i     (in_i.pixel_row),
    .in_pixel_col_i     (in_i.pixel_col),
    .in_color_i         (in_i.color),
    .out_ready_i        (out_o.ready),
    .out_valid_o        (out_o.valid),
    .out_upper_rgb_o    (out_o.upper_rgb),
    .out_lower_rgb_o    (out_o.lower_rgb),
    .out_row_address_o  (out_o.row_address),
    .out_column_index_o (out_o.column_index),
    .out_last_column_o  (out_o.last_column)
  );

  a_no_input_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == lmfs_pkg::ST_CLEAR) |-> !in_i.ready)
    else $error("input taken during clearing pass");

  a_scan_enters_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.opcode == lmfs_pkg::OP_SCAN)
      |=> (state == lmfs_pkg::ST_SCAN))
    else $error("scan item did not start a row scan");

  a_last_column_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last_column)
      |-> (out_o.column_index == lmfs_pkg::COL_IDX_W'(PANEL_WIDTH - 1)))
    else $error("last column flag on wrong column");

endmodule

`default_nettype wire

/* hw/rtl/lmfs_ctrl.sv */
// Control state machine: clear pass, pixel write sequencing and scan issue.
`default_nettype none

module lmfs_ctrl (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic [lmfs_pkg::OPCODE_W-1:0]       in_opcode_i,
  input  wire lmfs_pkg::sts_t                      sts_i,
  output logic                                     in_ready_o,
  output lmfs_pkg::cmd_t                           cmd_o,
  output lmfs_pkg::state_e                         state_o
);

  lmfs_pkg::state_e state_q, state_d;
  lmfs_pkg::op_e    op;
  logic             accept;

  assign op     = lmfs_pkg::op_e'(in_opcode_i);
  assign accept = in_valid_i && (state_q == lmfs_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      lmfs_pkg::ST_CLEAR: begin
        if (sts_i.clr_last) state_d = lmfs_pkg::ST_IDLE;
      end
      lmfs_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            lmfs_pkg::OP_SET:  state_d = lmfs_pkg::ST_PIX_WR;
            lmfs_pkg::OP_CLR:  state_d = lmfs_pkg::ST_PIX_WR;
            lmfs_pkg::OP_SCAN: state_d = lmfs_pkg::ST_SCAN;
            default:           state_d = lmfs_pkg::ST_IDLE;
          endcase
        end
      end
      lmfs_pkg::ST_PIX_WR: begin
        state_d = lmfs_pkg::ST_IDLE;
      end
      lmfs_pkg::ST_SCAN: begin
        // leave once the final column read has been issued
        if (sts_i.slot_free && sts_i.col_last) state_d = lmfs_pkg::ST_IDLE;
      end
      default: state_d = lmfs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == lmfs_pkg::ST_IDLE);
    cmd_o.clr_step    = (state_q == lmfs_pkg::ST_CLEAR);
    cmd_o.pix_accept  = accept && (op == lmfs_pkg::OP_SET || op == lmfs_pkg::OP_CLR);
    cmd_o.pix_wr      = (state_q == lmfs_pkg::ST_PIX_WR);
    cmd_o.scan_issue  = (state_q == lmfs_pkg::ST_SCAN) && sts_i.slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lmfs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

`default_nettype wire

/* hw/rtl/lmfs_dp.sv */
// Datapath: frame memories, clear counter, pixel latch, scan counters and output pipeline.
`default_nettype none

module lmfs_dp #(
  parameter int unsigned PANEL_WIDTH = lmfs_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned HALF_ROWS   = lmfs_pkg::HALF_ROWS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lmfs_pkg::cmd_t                       cmd_i,
  output lmfs_pkg::sts_t                            sts_o,
  input  wire logic [lmfs_pkg::OPCODE_W-1:0]        in_opcode_i,
  input  wire logic signed [lmfs_pkg::COORD_W-1:0]  in_pixel_row_i,
  input  wire logic signed [lmfs_pkg::COORD_W-1:0]  in_pixel_col_i,
  input  wire logic [lmfs_pkg::RGB_W-1:0]           in_color_i,
  input  wire logic                                 out_ready_i,
  output logic                                      out_valid_o,
  output logic [lmfs_pkg::RGB_W-1:0]                out_upper_rgb_o,
  output logic [lmfs_pkg::RGB_W-1:0]                out_lower_rgb_o,
  output logic [lmfs_pkg::ROW_ADDR_W-1:0]           out_row_address_o,
  output logic [lmfs_pkg::COL_IDX_W-1:0]            out_column_index_o,
  output logic                                      out_last_column_o
);

  localparam int unsigned RW        = $clog2(HALF_ROWS);
  localparam int unsigned CW        = $clog2(PANEL_WIDTH);
  localparam int unsigned AW        = RW + CW;
  localparam int unsigned MEM_DEPTH = HALF_ROWS * (2 ** CW);
  localparam int unsigned CRD_W     = lmfs_pkg::COORD_W - 1;
  localparam int unsigned RGB_W     = lmfs_pkg::RGB_W;

  logic [RGB_W-1:0] up_mem [MEM_DEPTH];
  logic [RGB_W-1:0] lo_mem [MEM_DEPTH];

  // clear pass
  logic [AW-1:0] clr_cnt_q;

  // pixel item latch
  logic [CRD_W-1:0] row7, col7, rr7;
  logic             in_lower, in_range;
  logic [AW-1:0]    in_addr;
  logic             is_set_q, lower_q, range_q;
  logic [AW-1:0]    pix_addr_q;
  logic [RGB_W-1:0] color_q, pix_up_q, pix_lo_q, pix_old;

  // scan counters and pipeline
  logic [RW-1:0]    scan_row_q;
  logic [CW-1:0]    col_q;
  logic             col_last, out_free, slot_free;
  logic             s1_vld_q;
  logic [RW-1:0]    s1_row_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_last_q;
  logic [RGB_W-1:0] rd_up_q, rd_lo_q;
  logic             out_vld_q;
  logic [RGB_W-1:0] out_up_q, out_lo_q;
  logic [RW-1:0]    out_row_q;
  logic [CW-1:0]    out_col_q;
  logic             out_last_q;

  // pixel coordinate decode; negative values fail the sign check
  assign row7     = in_pixel_row_i[CRD_W-1:0];
  assign col7     = in_pixel_col_i[CRD_W-1:0];
  assign in_lower = (row7 >= CRD_W'(HALF_ROWS));
  assign rr7      = in_lower ? (row7 - CRD_W'(HALF_ROWS)) : row7;
  assign in_range = !in_pixel_row_i[CRD_W] && (row7 < CRD_W'(2 * HALF_ROWS)) &&
                    !in_pixel_col_i[CRD_W] && (col7 < CRD_W'(PANEL_WIDTH));
  assign in_addr  = {rr7[RW-1:0], col7[CW-1:0]};

  assign col_last  = (col_q == CW'(PANEL_WIDTH - 1));
  assign out_free  = !out_vld_q || out_ready_i;
  assign slot_free = !s1_vld_q || out_free;
  assign pix_old   = lower_q ? pix_lo_q : pix_up_q;

  assign sts_o.clr_last  = (clr_cnt_q == AW'(MEM_DEPTH - 1));
  assign sts_o.col_last  = col_last;
  assign sts_o.slot_free = slot_free;

  // memory write port: clear pass or pixel update of one half
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      up_mem[clr_cnt_q] <= '0;
      lo_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.pix_wr && range_q) begin
      if (lower_q) begin
        lo_mem[pix_addr_q] <= is_set_q ? (pix_old | color_q) : '0;
      end else begin
        up_mem[pix_addr_q] <= is_set_q ? (pix_old | color_q) : '0;
      end
    end
  end

  // read port for pixel read-modify-write
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept) begin
      pix_up_q <= up_mem[in_addr];
      pix_lo_q <= lo_mem[in_addr];
    end
  end

  // read port for scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      rd_up_q <= up_mem[{scan_row_q, col_q}];
      rd_lo_q <= lo_mem[{scan_row_q, col_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_accept) begin
      is_set_q   <= (in_opcode_i == lmfs_pkg::OP_SET);
      lower_q    <= in_lower;
      range_q    <= in_range;
      pix_addr_q <= in_addr;
      color_q    <= in_color_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      scan_row_q <= '0;
      col_q      <= '0;
      s1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.scan_issue) begin
        if (col_last) begin
          col_q      <= '0;
          scan_row_q <= (scan_row_q == RW'(HALF_ROWS - 1)) ? '0 : scan_row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (cmd_i.scan_issue) begin
        s1_vld_q <= 1'b1;
      end else if (out_free) begin
        s1_vld_q <= 1'b0;
      end
      if (out_free) out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      s1_row_q  <= scan_row_q;
      s1_col_q  <= col_q;
      s1_last_q <= col_last;
    end
  end

  // hold the result while the sink stalls
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_up_q   <= rd_up_q;
      out_lo_q   <= rd_lo_q;
      out_row_q  <= s1_row_q;
      out_col_q  <= s1_col_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_upper_rgb_o    = out_up_q;
  assign out_lower_rgb_o    = out_lo_q;
  assign out_row_address_o  = lmfs_pkg::ROW_ADDR_W'(out_row_q);
  assign out_column_index_o = lmfs_pkg::COL_IDX_W'(out_col_q);
  assign out_last_column_o  = out_last_q;

endmodule

`default_nettype wire

/* dv/tb_led_matrix_frame_scan.sv */
// Self-checking testbench for the LED matrix frame store and row-pair scanner.
module tb_led_matrix_frame_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import lmfs_pkg::*;

  localparam int PANEL_W  = PANEL_WIDTH_DEF;
  localparam int HALF     = HALF_ROWS_DEF;
  localparam int IDLE_PCT = 37;
  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [RGB_W-1:0]      upper;
    logic [RGB_W-1:0]      lower;
    logic [ROW_ADDR_W-1:0] row;
    logic [COL_IDX_W-1:0]  col;
    logic                  last;
  } column_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lmfs_in_if  pix_ch ();
  lmfs_out_if col_ch ();

  led_matrix_frame_scan DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (pix_ch),
    .out_o  (col_ch)
  );

  always #6 clk_i = ~clk_i;

  // Predicted panel contents: bits 2..0 upper color, bits 5..3 lower color.
  logic [5:0]            frame_cells [HALF][PANEL_W];
  logic [ROW_ADDR_W-1:0] next_scan_row;
  column_t               column_q [$];
  int                    fail_cnt;
  bit                    send_gaps_on;
  bit                    sink_stalls_on;

  task automatic update_frame(input logic [OPCODE_W-1:0] op, input logic signed [7:0] prow,
                              input logic signed [7:0] pcol, input logic [RGB_W-1:0] rgb);
    int      r;
    int      c;
    int      pair;
    column_t cv;
    r = prow;
    c = pcol;
    if (op == OP_SET || op == OP_CLR) begin
      if (r < 0 || r >= 2 * HALF || c < 0 || c >= PANEL_W) return;
      pair = (r >= HALF) ? r - HALF : r;
      if (op == OP_SET) begin
        if (r >= HALF) frame_cells[pair][c][5:3] |= rgb;
        else frame_cells[pair][c][2:0] |= rgb;
      end else begin
        if (r >= HALF) frame_cells[pair][c][5:3] = '0;
        else frame_cells[pair][c][2:0] = '0;
      end
    end else if (op == OP_SCAN) begin
      pair = (next_scan_row >= HALF) ? 0 : next_scan_row;
      for (int k = 0; k < PANEL_W; k++) begin
        cv.upper = frame_cells[pair][k][2:0];
        cv.lower = frame_cells[pair][k][5:3];
        cv.row   = pair[ROW_ADDR_W-1:0];
        cv.col   = k[COL_IDX_W-1:0];
        cv.last  = (k == PANEL_W - 1);
        column_q.push_back(cv);
      end
      next_scan_row = (pair + 1 >= HALF) ? '0 : ROW_ADDR_W'(pair + 1);
    end
  endtask

  task automatic send_item(input logic [OPCODE_W-1:0] op, input int prow, input int pcol,
                           input int rgb);
    while (send_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.opcode    <= op;
    pix_ch.pixel_row <= prow[7:0];
    pix_ch.pixel_col <= pcol[7:0];
    pix_ch.color     <= rgb[RGB_W-1:0];
    do @(posedge clk_i); while (!pix_ch.ready);
    update_frame(op, prow[7:0], pcol[7:0], rgb[RGB_W-1:0]);
  endtask

  // Drop valid and hold off until every predicted column has been seen.
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    do @(posedge clk_i); while (column_q.size() != 0);
  endtask

  // Returns 1 when the item does real work (not an ignored one).
  task automatic send_random(output bit useful);
    int kind;
    kind = $urandom_range(99);
    useful = (kind < 90);
    if (kind < 45)
      send_item(OP_SET, $urandom_range(2 * HALF - 1), $urandom_range(PANEL_W - 1),
                $urandom_range(7));
    else if (kind < 60)
      send_item(OP_CLR, $urandom_range(2 * HALF - 1), $urandom_range(PANEL_W - 1),
                $urandom_range(7));
    else if (kind < 90)
      send_item(OP_SCAN, $urandom_range(255), $urandom_range(255), $urandom_range(7));
    else if (kind < 95)
      send_item(OP_NONE, $urandom_range(2 * HALF - 1), $urandom_range(PANEL_W - 1),
                $urandom_range(7));
    else if ($urandom_range(1))
      send_item(logic'($urandom_range(1)) ? OP_SET : OP_CLR, $urandom_range(2 * HALF, 255),
                $urandom_range(PANEL_W - 1), $urandom_range(7));
    else
      send_item(logic'($urandom_range(1)) ? OP_SET : OP_CLR, $urandom_range(2 * HALF - 1),
                $urandom_range(PANEL_W, 255), $urandom_range(7));
  endtask

  task automatic test_pixel_edges();
    send_item(OP_SET, 0, 0, 7);
    send_item(OP_SET, 2 * HALF - 1, PANEL_W - 1, 7);
    send_item(OP_SET, HALF - 1, PANEL_W - 1, 2);
    send_item(OP_SET, HALF, 0, 5);
    send_item(OP_SET, 0, 1, 1);
    send_item(OP_SET, 0, 1, 6);           // OR onto existing color
    send_item(OP_SET, HALF, 1, 3);
    send_item(OP_CLR, HALF, 1, 0);        // lower half only
    send_item(OP_SET, 0, 2, 4);
    send_item(OP_SET, HALF, 2, 4);
    send_item(OP_CLR, 0, 2, 7);           // upper half only
    send_item(OP_SET, -128, 0, 7);        // off the panel: ignored
    send_item(OP_SET, 2 * HALF, 3, 7);
    send_item(OP_SET, 0, PANEL_W, 7);
    send_item(OP_CLR, 0, -1, 7);
    send_item(OP_CLR, 127, 127, 7);
    send_item(OP_NONE, 0, 0, 0);          // unused opcode
    send_item(OP_SCAN, -1, -1, 7);        // pixel fields ignored on scan
    send_item(OP_SCAN, 0, 0, 0);
    send_item(OP_CLR, 0, 0, 0);
    send_item(OP_SCAN, 5, 5, 5);
  endtask

  task automatic test_drain_pause();
    send_item(OP_SET, 1, 10, 3);
    send_item(OP_SET, HALF + 1, 20, 6);
    wait_drained();
    send_item(OP_SCAN, 0, 0, 0);
  endtask

  task automatic test_no_idle();
    bit useful;
    send_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    for (int n = 0; n < 30; n += useful) send_random(useful);
    send_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  task automatic test_random_mix();
    bit useful;
    for (int n = 0; n < 50; n += useful) send_random(useful);
  endtask

  function automatic void report(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch expected %0d actual %0d", $time, field, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Column checker and random stall on the result side.
  always @(posedge clk_i) begin
    column_t got;
    column_t exp_c;
    if (!rst_ni) begin
      col_ch.ready <= 1'b0;
    end else begin
      if (col_ch.valid && col_ch.ready) begin
        got = '{col_ch.upper_rgb, col_ch.lower_rgb, col_ch.row_address,
                col_ch.column_index, col_ch.last_column};
        if (column_q.size() == 0) begin
          $display("%0t: unexpected column expected none actual %p", $time, got);
          fail_cnt++;
        end else begin
          exp_c = column_q.pop_front();
          report("upper_rgb", exp_c.upper, got.upper);
          report("lower_rgb", exp_c.lower, got.lower);
          report("row_address", exp_c.row, got.row);
          report("column_index", exp_c.col, got.col);
          report("last_column", exp_c.last, got.last);
        end
      end
      col_ch.ready <= !sink_stalls_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    fail_cnt       = 0;
    send_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    next_scan_row  = '0;
    foreach (frame_cells[i, j]) frame_cells[i][j] = '0;
    rst_ni           <= 1'b0;
    pix_ch.valid     <= 1'b0;
    pix_ch.opcode    <= OP_SET;
    pix_ch.pixel_row <= '0;
    pix_ch.pixel_col <= '0;
    pix_ch.color     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_pixel_edges();
    test_drain_pause();
    test_no_idle();
    test_random_mix();

    wait_drained();
    repeat (2 * PANEL_W) @(posedge clk_i);
    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
